[rtl/uscd_pkg.sv]
// ----------------------------------------------------------------------------
// uscd_pkg: shared types and constants of the Unix time to calendar converter
// Holds the controller-to-datapath command and status structs, the
// division constants and the month length table.
// ----------------------------------------------------------------------------
package uscd_pkg;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [6:0]  BASE_MOD100   = 7'd70;
  localparam logic [8:0]  BASE_MOD400   = 9'd370;
  localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
  localparam logic [8:0]  YEAR_LEN      = 9'd365;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // Reciprocals: seconds/128 over 675 (shift 35), seconds over 3600 (shift 29),
  // over 60 (shift 18); widths match the products they feed
  localparam logic [50:0] DAY_RECIP     = 51'd50903317;
  localparam logic [34:0] HOUR_RECIP    = 35'd149131;
  localparam logic [24:0] MIN_RECIP     = 25'd4370;

  typedef struct packed {
    logic load;
    logic day_quot;
    logic day_rem;
    logic hour_quot;
    logic hour_rem;
    logic min_quot;
    logic min_rem;
    logic year_step;
    logic month_step;
  } cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/unix_seconds_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date: Unix time to Gregorian date and time of day
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year,
// month, day, hour, minute and second.
//
// Request channel: drive in_unix_seconds and raise start; the request is
// taken at a rising edge with start high and busy low. busy stays high until
// the result has been strobed, and start is ignored meanwhile.
// Result channel: out_valid is high for exactly one cycle with the date on
// the out_cal_* ports; the receiver must take it in that cycle, it cannot
// stall the block. The fields hold their values until the next request.
// The strobe follows the day, hour and minute divisions by reciprocal
// multiplication, quotient and remainder in separate states, and then the
// year and month loops, which subtract one whole year and one whole month
// per cycle. A new request is taken the cycle after the strobe.
// Synchronous reset returns the sequencer to idle, with no result pending;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date
  import uscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_unix_seconds,
  output logic        out_valid,
  output logic [11:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_cal_hour,
  output logic [5:0]  out_cal_minute,
  output logic [5:0]  out_cal_second
);

  cmd_t cmd;
  sts_t sts;

  uscd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  uscd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_unix_seconds (in_unix_seconds),
    .out_cal_year    (out_cal_year),
    .out_cal_month   (out_cal_month),
    .out_cal_day     (out_cal_day),
    .out_cal_hour    (out_cal_hour),
    .out_cal_minute  (out_cal_minute),
    .out_cal_second  (out_cal_second)
  );

endmodule

[rtl/uscd_ctrl.sv]
// ----------------------------------------------------------------------------
// uscd_ctrl: sequencer of the Unix time to calendar converter
// Steps the datapath through the day, hour and minute divisions, then
// through the year and month subtraction loops, and strobes the result.
// ----------------------------------------------------------------------------
module uscd_ctrl
  import uscd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DAY_Q  = 4'd1;
  localparam logic [3:0] ST_DAY_R  = 4'd2;
  localparam logic [3:0] ST_HOUR_Q = 4'd3;
  localparam logic [3:0] ST_HOUR_R = 4'd4;
  localparam logic [3:0] ST_MIN_Q  = 4'd5;
  localparam logic [3:0] ST_MIN_R  = 4'd6;
  localparam logic [3:0] ST_YEAR   = 4'd7;
  localparam logic [3:0] ST_MONTH  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DAY_Q;
        end
      end
      ST_DAY_Q: begin
        cmd.day_quot = 1'b1;
        state_nxt    = ST_DAY_R;
      end
      ST_DAY_R: begin
        cmd.day_rem = 1'b1;
        state_nxt   = ST_HOUR_Q;
      end
      ST_HOUR_Q: begin
        cmd.hour_quot = 1'b1;
        state_nxt     = ST_HOUR_R;
      end
      ST_HOUR_R: begin
        cmd.hour_rem = 1'b1;
        state_nxt    = ST_MIN_Q;
      end
      ST_MIN_Q: begin
        cmd.min_quot = 1'b1;
        state_nxt    = ST_MIN_R;
      end
      ST_MIN_R: begin
        cmd.min_rem = 1'b1;
        state_nxt   = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts.year_fits) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.month_fits) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == ST_DAY_Q))
    else $error("request accepted but conversion did not begin");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_MONTH && $past(sts.month_fits)))
    else $error("result strobe without a finished month search");

endmodule

[rtl/uscd_dp.sv]
// ----------------------------------------------------------------------------
// uscd_dp: datapath of the Unix time to calendar converter
// Reciprocal multiplication splits off days, hours and minutes, quotient
// and remainder in separate cycles, then one year or one month is
// subtracted per cycle from the day count.
// ----------------------------------------------------------------------------
module uscd_dp
  import uscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] in_unix_seconds,
  output logic [11:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_cal_hour,
  output logic [5:0]  out_cal_minute,
  output logic [5:0]  out_cal_second
);

  logic [31:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [11:0] year_r, year_nxt;
  logic [6:0]  mod100_r, mod100_nxt;
  logic [8:0]  mod400_r, mod400_nxt;
  logic [3:0]  month_r, month_nxt;

  logic [50:0] prod_day;
  logic [34:0] prod_hour;
  logic [24:0] prod_min;
  logic [31:0] day_span;
  logic [31:0] hour_span;
  logic [31:0] min_span;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign prod_day  = {26'd0, rem_r[31:7]} * DAY_RECIP;
  assign prod_hour = {18'd0, rem_r[16:0]} * HOUR_RECIP;
  assign prod_min  = {13'd0, rem_r[11:0]} * MIN_RECIP;

  assign day_span  = {16'd0, days_r} * SECS_PER_DAY;
  assign hour_span = {27'd0, hour_r} * SECS_PER_HOUR;
  assign min_span  = {26'd0, min_r} * SECS_PER_MIN;

  assign leap = ((year_r[1:0] == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign ylen = leap ? LEAP_YEAR_LEN : YEAR_LEN;
  assign mlen = month_len(month_r, leap);

  assign sts.year_fits  = (days_r < {7'd0, ylen});
  assign sts.month_fits = (month_r == LAST_MONTH) || (days_r < {11'd0, mlen});

  always_comb begin
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    year_nxt   = year_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    month_nxt  = month_r;
    if (cmd.load) begin
      rem_nxt    = in_unix_seconds;
      days_nxt   = '0;
      hour_nxt   = '0;
      min_nxt    = '0;
      year_nxt   = BASE_YEAR;
      mod100_nxt = BASE_MOD100;
      mod400_nxt = BASE_MOD400;
      month_nxt  = '0;
    end else if (cmd.day_quot) begin
      days_nxt = prod_day[50:35];
    end else if (cmd.day_rem) begin
      rem_nxt = rem_r - day_span;
    end else if (cmd.hour_quot) begin
      hour_nxt = prod_hour[33:29];
    end else if (cmd.hour_rem) begin
      rem_nxt = rem_r - hour_span;
    end else if (cmd.min_quot) begin
      min_nxt = prod_min[23:18];
    end else if (cmd.min_rem) begin
      rem_nxt = rem_r - min_span;
    end else if (cmd.year_step) begin
      days_nxt   = days_r - {7'd0, ylen};
      year_nxt   = year_r + 12'd1;
      mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
      mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
    end else if (cmd.month_step) begin
      days_nxt  = days_r - {11'd0, mlen};
      month_nxt = month_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= '0;
    end else begin
      month_r <= month_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    days_r   <= days_nxt;
    hour_r   <= hour_nxt;
    min_r    <= min_nxt;
    year_r   <= year_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
  end

  assign out_cal_year   = year_r;
  assign out_cal_month  = month_r + 4'd1;
  assign out_cal_day    = days_r[4:0] + 5'd1;
  assign out_cal_hour   = hour_r;
  assign out_cal_minute = min_r;
  assign out_cal_second = rem_r[5:0];

endmodule

[tb/unix_seconds_to_calendar_date_tb.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_tb: self-checking bench for the Unix time
// to calendar date converter
// Sends directed corner timestamps (epoch, day, month, year and century
// boundaries, leap days, the 2038 rollover, the all-ones input), then random
// timestamps, most of them placed near calendar boundaries. Each accepted
// request is converted by an internal calendar model and every strobed result
// is compared field by field against the oldest prediction. Sender gaps fall
// at random points of the conversion; the final stretch runs back to back.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date_tb;
  import uscd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_COUNT  = 1330;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE_CYCLES = 200;
  localparam int SECS_IN_DAY   = 86400;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  class date_checker;
    cal_date_t expected_dates[$];
    int        mismatches;

    static function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned year_days(int unsigned y);
      return is_leap(y) ? 366 : 365;
    endfunction

    static function int unsigned month_days(int unsigned m, int unsigned y);
      int unsigned len;
      case (m)
        3, 5, 8, 10: len = 30;
        1:           len = is_leap(y) ? 29 : 28;
        default:     len = 31;
      endcase
      return len;
    endfunction

    static function cal_date_t to_calendar(logic [31:0] secs);
      int unsigned days;
      int unsigned rest;
      int unsigned yr;
      int unsigned mo;
      cal_date_t   d;
      days = secs / SECS_IN_DAY;
      rest = secs % SECS_IN_DAY;
      yr   = 1970;
      mo   = 0;
      while (days >= year_days(yr)) begin
        days -= year_days(yr);
        yr++;
      end
      while (mo < 11 && days >= month_days(mo, yr)) begin
        days -= month_days(mo, yr);
        mo++;
      end
      d.year   = yr[11:0];
      d.month  = 4'(mo + 1);
      d.day    = 5'(days + 1);
      d.hour   = 5'(rest / 3600);
      d.minute = 6'((rest % 3600) / 60);
      d.second = 6'(rest % 60);
      return d;
    endfunction

    function void note_request(logic [31:0] secs);
      expected_dates.push_back(to_calendar(secs));
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction

    function void check_result(cal_date_t got);
      cal_date_t want;
      if (expected_dates.size() == 0) begin
        $error("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
               got.day, got.hour, got.minute, got.second);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      if (got.year != want.year) begin
        $error("cal_year: expected %0d, got %0d", want.year, got.year);
        mismatches++;
      end
      if (got.month != want.month) begin
        $error("cal_month: expected %0d, got %0d", want.month, got.month);
        mismatches++;
      end
      if (got.day != want.day) begin
        $error("cal_day: expected %0d, got %0d", want.day, got.day);
        mismatches++;
      end
      if (got.hour != want.hour) begin
        $error("cal_hour: expected %0d, got %0d", want.hour, got.hour);
        mismatches++;
      end
      if (got.minute != want.minute) begin
        $error("cal_minute: expected %0d, got %0d", want.minute, got.minute);
        mismatches++;
      end
      if (got.second != want.second) begin
        $error("cal_second: expected %0d, got %0d", want.second, got.second);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_unix_seconds;
  logic        out_valid;
  logic [11:0] out_cal_year;
  logic [3:0]  out_cal_month;
  logic [4:0]  out_cal_day;
  logic [4:0]  out_cal_hour;
  logic [5:0]  out_cal_minute;
  logic [5:0]  out_cal_second;

  date_checker dates;
  int          cycle_count;

  unix_seconds_to_calendar_date u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_unix_seconds(in_unix_seconds),
    .out_valid      (out_valid),
    .out_cal_year   (out_cal_year),
    .out_cal_month  (out_cal_month),
    .out_cal_day    (out_cal_day),
    .out_cal_hour   (out_cal_hour),
    .out_cal_minute (out_cal_minute),
    .out_cal_second (out_cal_second)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("unix_seconds_to_calendar_date_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      dates.check_result('{out_cal_year, out_cal_month, out_cal_day,
                           out_cal_hour, out_cal_minute, out_cal_second});
    end
  end

  task automatic send_request(input logic [31:0] secs);
    @(negedge clk);
    start           <= 1'b1;
    in_unix_seconds <= secs;
    do @(posedge clk); while (busy);
    dates.note_request(secs);
  endtask

  task automatic hold_requests(input int cycles);
    @(negedge clk);
    start           <= 1'b0;
    in_unix_seconds <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (dates.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] near_boundary();
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    longint      total;
    yr    = $urandom_range(2106, 1970);
    mo    = $urandom_range(11, 0);
    dy    = ($urandom_range(1, 0) == 1) ? 0 :
            $urandom_range(date_checker::month_days(mo, yr) - 1, 0);
    total = 0;
    for (int unsigned y = 1970; y < yr; y++) total += date_checker::year_days(y);
    for (int unsigned m = 0; m < mo; m++) total += date_checker::month_days(m, yr);
    total = (total + dy) * SECS_IN_DAY;
    case ($urandom_range(3, 0))
      0:       total += $urandom_range(3, 0);
      1:       total -= $urandom_range(3, 1);
      2:       total += $urandom_range(SECS_IN_DAY - 1, 0);
      default: total += SECS_IN_DAY - 1;
    endcase
    if (total < 0 || total > 64'hFFFF_FFFF) return $urandom;
    return total[31:0];
  endfunction

  initial begin
    logic [31:0] corner_secs[$];
    logic [31:0] secs;
    dates           = new();
    cycle_count     = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_unix_seconds = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    corner_secs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                    32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                    32'd94694399, 32'd946684799, 32'd951782400, 32'd951868800,
                    32'd978307199, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4107456000,
                    32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
    foreach (corner_secs[i]) send_request(corner_secs[i]);
    drain_results();

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: secs = near_boundary();
        6:                secs = 32'hFFFF_FFFF - $urandom_range(400000, 0);
        default:          secs = $urandom;
      endcase
      send_request(secs);
      if (i == 400 || i == 900) begin
        drain_results();
      end else if (i < RANDOM_COUNT - QUIET_TAIL) begin
        case ($urandom_range(3, 0))
          0: hold_requests($urandom_range(17, 1));
          1: begin
            drain_results();
            hold_requests($urandom_range(17, 1));
          end
          default: ;
        endcase
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (dates.mismatches == 0 && dates.pending() == 0) begin
      $display("unix_seconds_to_calendar_date_tb: PASS");
    end else begin
      $display("unix_seconds_to_calendar_date_tb: FAIL");
    end
    $finish;
  end

endmodule

[unix_seconds_to_calendar_date.f]
rtl/uscd_pkg.sv
rtl/uscd_ctrl.sv
rtl/uscd_dp.sv
rtl/unix_seconds_to_calendar_date.sv
tb/unix_seconds_to_calendar_date_tb.sv
